>>> hdl/erl_pkg.sv
// erl_pkg: shared constants, payload structs and controller/datapath
// command and status types for the event ring log core.
// No dependencies.
package erl_pkg;

  // default geometry
  localparam int unsigned DepthDefault   = 64;
  localparam int unsigned TextMaxDefault = 63;

  // most entry results a single sync may emit before its summary
  localparam logic [5:0] EntryRoomLast = 6'd63;

  // input action codes
  localparam logic [1:0] ACT_STAGE = 2'd0;
  localparam logic [1:0] ACT_LOG   = 2'd1;
  localparam logic [1:0] ACT_SYNC  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // result kind codes
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_SUM   = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_BYTE  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  context_byte;
    logic [7:0]  event_type;
    logic [31:0] pid;
    logic [63:0] time_stamp;
    logic [5:0]  slot_index;
    logic [5:0]  byte_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [5:0]  entry_slot;
    logic [5:0]  entry_length;
    logic [31:0] entry_process;
    logic [63:0] entry_time;
    logic [7:0]  read_byte;
    logic [6:0]  persisted_count;
    logic        last_of_run;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;     // input transaction taken this cycle
    logic       sync_init;  // load walk cursor from sync cursor
    logic       sync_step;  // retire current slot of the walk
    logic       sync_done;  // move sync cursor to the head
    logic       out_load;   // load output register
    logic [1:0] out_sel;    // kind of result to load
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result
    logic at_head;    // sync cursor sits on the head
    logic match;      // fetched slot has the commit type
    logic room;       // entry results still allowed in this sync
    logic last_slot;  // walk cursor is one before the head
  } status_t;

endpackage

>>> hdl/erl_ctrl.sv
// erl_ctrl: sequencing state machine for the event ring log core.
// Depends on erl_pkg for command, status and code definitions.
module erl_ctrl import erl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_ready_o,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_SYNC  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_SUM   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (action_i == ACT_SYNC) begin
            state_d = ST_SYNC;
          end else if (action_i == ACT_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = KIND_BYTE;
          state_d        = ST_IDLE;
        end
      end
      ST_SYNC: begin
        if (status_i.at_head) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = KIND_NONE;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.sync_init = 1'b1;
          state_d         = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // slot memories read at the walk cursor
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.match && status_i.room) begin
          if (status_i.out_free) begin
            cmd_o.out_load  = 1'b1;
            cmd_o.out_sel   = KIND_ENTRY;
            cmd_o.sync_step = 1'b1;
            state_d         = status_i.last_slot ? ST_SUM : ST_FETCH;
          end
        end else begin
          cmd_o.sync_step = 1'b1;
          state_d         = status_i.last_slot ? ST_SUM : ST_FETCH;
        end
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = KIND_SUM;
          cmd_o.sync_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/erl_datapath.sv
// erl_datapath: slot memories, ring pointers, sync walk and output register
// for the event ring log core. Depends on erl_pkg.
module erl_datapath import erl_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned TEXT_MAX = TextMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_t       out_data_o,
  input  cmd_t       cmd_i,
  output status_t    status_o
);

  localparam int unsigned PW     = $clog2(DEPTH);
  localparam int unsigned FW     = $clog2(DEPTH + 1);
  localparam int unsigned LW     = $clog2(TEXT_MAX + 1);
  localparam int unsigned TW     = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int unsigned TDEPTH = DEPTH * (2 ** TW);

  // slot storage
  logic [63:0]   time_mem [DEPTH];
  logic [7:0]    type_mem [DEPTH];
  logic [31:0]   proc_mem [DEPTH];
  logic [LW-1:0] len_mem  [DEPTH];
  logic [7:0]    text_mem [TDEPTH];

  logic [63:0]   time_rd_q;
  logic [7:0]    type_rd_q;
  logic [31:0]   proc_rd_q;
  logic [LW-1:0] len_rd_q;
  logic [7:0]    text_rd_q;

  // ring state
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] oldest_q, oldest_d;
  logic [PW-1:0] sync_q, sync_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [LW-1:0] staged_q, staged_d;
  logic [7:0]    commit_q;

  // walk state
  logic [PW-1:0] cur_q, cur_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [5:0]    emit_q, emit_d;

  // context read request
  logic          rd_ok_q;
  logic [5:0]    off_q;

  // output register
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          do_stage, do_log, do_read;
  logic [PW-1:0] wp_next, oldest_next, cur_next, slot_addr;
  logic          match, room;
  logic [7:0]    byte_val;

  assign do_stage = cmd_i.accept && (in_data_i.action == ACT_STAGE)
                    && (in_data_i.context_byte != 8'd0) && (staged_q < LW'(TEXT_MAX));
  assign do_log   = cmd_i.accept && (in_data_i.action == ACT_LOG);
  assign do_read  = cmd_i.accept && (in_data_i.action == ACT_READ);

  assign wp_next     = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
  assign oldest_next = (oldest_q == PW'(DEPTH - 1)) ? '0 : oldest_q + PW'(1);
  assign cur_next    = (cur_q == PW'(DEPTH - 1)) ? '0 : cur_q + PW'(1);

  // one slot read port shared by context reads and the sync walk
  assign slot_addr = cmd_i.accept ? PW'(in_data_i.slot_index) : cur_q;

  assign match = (type_rd_q == commit_q);
  assign room  = (emit_q != EntryRoomLast);

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.at_head   = (sync_q == wp_q);
  assign status_o.match     = match;
  assign status_o.room      = room;
  assign status_o.last_slot = (cur_next == wp_q);

  // slot memories: written by log, read at the shared address
  always_ff @(posedge clk_i) begin
    if (do_log) begin
      time_mem[wp_q] <= in_data_i.time_stamp;
      type_mem[wp_q] <= in_data_i.event_type;
      proc_mem[wp_q] <= in_data_i.pid;
      len_mem[wp_q]  <= staged_q;
    end
    time_rd_q <= time_mem[slot_addr];
    type_rd_q <= type_mem[slot_addr];
    proc_rd_q <= proc_mem[slot_addr];
    len_rd_q  <= len_mem[slot_addr];
  end

  // context text memory, read data held until the next read
  always_ff @(posedge clk_i) begin
    if (do_stage) begin
      text_mem[{wp_q, TW'(staged_q)}] <= in_data_i.context_byte;
    end
    if (do_read) begin
      text_rd_q <= text_mem[{PW'(in_data_i.slot_index), TW'(in_data_i.byte_offset)}];
    end
  end

  // read request qualifiers, taken with the transaction
  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rd_ok_q <= (32'(in_data_i.slot_index) < 32'(DEPTH))
                 && (32'(in_data_i.slot_index) < 32'(fill_q))
                 && (32'(in_data_i.byte_offset) < 32'(TEXT_MAX));
      off_q   <= in_data_i.byte_offset;
    end
  end

  // ring pointer and staging updates
  always_comb begin
    wp_d     = wp_q;
    oldest_d = oldest_q;
    sync_d   = sync_q;
    fill_d   = fill_q;
    staged_d = staged_q;
    if (do_stage) begin
      staged_d = staged_q + LW'(1);
    end
    if (do_log) begin
      staged_d = '0;
      wp_d     = wp_next;
      if (fill_q < FW'(DEPTH)) begin
        fill_d = fill_q + FW'(1);
      end else begin
        oldest_d = oldest_next;
        if (sync_q == oldest_q) begin
          sync_d = oldest_next;
        end
      end
    end
    if (cmd_i.sync_done) begin
      sync_d = wp_q;
    end
  end

  // sync walk counters; a context read parks the cursor on its slot
  always_comb begin
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    emit_d = emit_q;
    if (cmd_i.sync_init) begin
      cur_d  = sync_q;
      cnt_d  = '0;
      emit_d = '0;
    end else if (do_read) begin
      cur_d = PW'(in_data_i.slot_index);
    end else if (cmd_i.sync_step) begin
      cur_d = cur_next;
      if (match) begin
        cnt_d = cnt_q + 7'd1;
        if (room) begin
          emit_d = emit_q + 6'd1;
        end
      end
    end
  end

  // context byte, zero for an out-of-range request or past the stored length
  assign byte_val = (rd_ok_q && (32'(off_q) < 32'(len_rd_q))) ? text_rd_q : 8'd0;

  // output register load
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.out_load) begin
      out_valid_d       = 1'b1;
      out_d             = '0;
      out_d.result_kind = cmd_i.out_sel;
      case (cmd_i.out_sel)
        KIND_ENTRY: begin
          out_d.entry_slot    = 6'(cur_q);
          out_d.entry_length  = 6'(len_rd_q);
          out_d.entry_process = proc_rd_q;
          out_d.entry_time    = time_rd_q;
        end
        KIND_SUM: begin
          out_d.persisted_count = cnt_d;
          out_d.last_of_run     = 1'b1;
        end
        KIND_NONE: begin
          out_d.last_of_run = 1'b1;
        end
        KIND_BYTE: begin
          out_d.read_byte   = byte_val;
          out_d.last_of_run = 1'b1;
        end
        default: begin
          out_d.last_of_run = 1'b1;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      oldest_q    <= '0;
      sync_q      <= '0;
      fill_q      <= '0;
      staged_q    <= '0;
      commit_q    <= 8'd1;
      cur_q       <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      oldest_q    <= oldest_d;
      sync_q      <= sync_d;
      fill_q      <= fill_d;
      staged_q    <= staged_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        commit_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/event_ring_log_with_sync_cursor_core.sv
// Stage and log transactions may follow back to back.
// A context read result is loaded into the output register from the read state,
// as input reopens; a waiting result holds it off.
// A sync walk loads the cursor, then fetches and checks each walked slot and ends
// with the summary, input held meanwhile; a sync with nothing new gives a none result.
// Async active-low reset clears pointers, counts, output valid; commit type is 1.
module event_ring_log_with_sync_cursor_core import erl_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned TEXT_MAX = TextMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  erl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage and result datapath
  erl_datapath #(
    .DEPTH    (DEPTH),
    .TEXT_MAX (TEXT_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
